// File: hw/rtl/assert_macros.svh
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// File: hw/rtl/ppq_pkg.sv
// ----------------------------------------------------------------------------
// ppq_pkg
// Types and codes shared by the pending packet queue modules.
// ----------------------------------------------------------------------------
package ppq_pkg;
  localparam logic [1:0] MODE_ENQ  = 2'd0;
  localparam logic [1:0] MODE_DEQ  = 2'd1;
  localparam logic [1:0] MODE_FIND = 2'd2;
  localparam logic [1:0] MODE_DROP = 2'd3;

  localparam logic [2:0] ST_ENQUEUED = 3'd0;
  localparam logic [2:0] ST_DUP      = 3'd1;
  localparam logic [2:0] ST_FOUND    = 3'd2;
  localparam logic [2:0] ST_NOTFOUND = 3'd3;
  localparam logic [2:0] ST_DROPDONE = 3'd4;

  localparam logic CFG_MAX_LEN = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  typedef struct packed {
    logic [31:0] uid;
    logic [31:0] dst;
    logic [31:0] expire;
    logic        notify;
  } entry_t;
endpackage

// File: hw/rtl/pending_packet_queue_with_expiry.sv
// ----------------------------------------------------------------------------
// pending_packet_queue_with_expiry
// Ordered queue of packets waiting for a route, with expiry and eviction.
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH cells, oldest in cell 0. A request is
// handled by a sequencer that visits one cell position per cycle; removing
// an entry shifts every cell above it down by one in that same cycle, so the
// scan stays at the same position. A drop request removes every entry for its
// destination; any other request first purges expired entries and then scans
// for its match, and an enqueue with no duplicate evicts the oldest entry when
// the queue is at its length limit and appends the new one. Result words leave
// while the scan goes on; the scan stalls while a waiting word is held off
// by a low out_tready. One request is in progress at a time; a new word is
// taken once the final result of the previous one has been delivered.
module pending_packet_queue_with_expiry #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  // tdata: mode[1:0], now[33:2], packet_uid[65:34], dst_addr[97:66],
  // notify_on_drop[98], zero fill to 104 bits
  input  logic [103:0]  in_tdata,
  output logic          out_tvalid,
  input  logic          out_tready,
  // tdata: status[2:0], drop_reason[3], out_uid[35:4], out_dst[67:36],
  // out_expire[99:68], zero fill to 104 bits
  output logic [103:0]  out_tdata,
  // tuser: kind
  output logic          out_tuser,
  output logic          out_tlast,
  input  logic          cfg_we,
  input  logic [0:0]    cfg_index,
  input  logic [31:0]   cfg_wdata
);
  localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PURGE, S_LOOK, S_EVICT, S_OUT, S_DROP
  } state_t;

  state_t          state_r;
  logic [1:0]      mode_r;
  logic [31:0]     now_r, uid_r, dst_r;
  logic            notify_r;
  logic [5:0]      max_len_r;
  logic [31:0]     timeout_r;
  logic [CW-1:0]   count_r;
  logic [CW-1:0]   pos_r;
  logic            ovalid_r, olast_r, okind_r, oreason_r;
  logic [2:0]      ostatus_r;
  ppq_pkg::entry_t oent_r;

  ppq_pkg::entry_t ents [QUEUE_DEPTH];
  logic            vals [QUEUE_DEPTH];
  logic            shift [QUEUE_DEPTH];
  logic            load  [QUEUE_DEPTH];
  logic            rm_now, app_now;
  ppq_pkg::entry_t new_ent;
  ppq_pkg::entry_t cur;
  logic [IW-1:0]   pidx;
  logic [32:0]     sum;
  logic [31:0]     expire;
  logic [CW-1:0]   limit;

  assign pidx = pos_r[IW-1:0];
  assign cur  = ents[pidx];
  assign sum  = {1'b0, now_r} + {1'b0, timeout_r};
  assign expire = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
  assign new_ent = '{uid: uid_r, dst: dst_r, expire: expire, notify: notify_r};

  always_comb begin
    if (max_len_r == 6'd0) begin
      limit = CW'(1);
    end else if (32'(max_len_r) > 32'(QUEUE_DEPTH)) begin
      limit = CW'(QUEUE_DEPTH);
    end else begin
      limit = CW'(max_len_r);
    end
  end

  // Cell-row control: remove at pos (shift down from pos up), or append at count.
  always_comb begin
    rm_now  = 1'b0;
    app_now = 1'b0;
    if (!ovalid_r || out_tready) begin
      unique case (state_r)
        S_PURGE: rm_now = (pos_r < count_r) && (cur.expire < now_r) &&
                          !(cur.notify && ovalid_r && !out_tready);
        S_DROP:  rm_now = (pos_r < count_r) && (cur.dst == dst_r);
        S_EVICT: rm_now = 1'b1;
        S_LOOK:  rm_now = (mode_r == ppq_pkg::MODE_DEQ) && (pos_r < count_r) &&
                          (cur.dst == dst_r);
        S_OUT:   app_now = (count_r < CW'(QUEUE_DEPTH));
        default: ;
      endcase
    end
  end

  genvar g;
  generate
    for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      ppq_pkg::entry_t rent;
      logic            rval;
      if (g == QUEUE_DEPTH - 1) begin : g_end
        assign rent = ents[g];
        assign rval = 1'b0;
      end else begin : g_mid
        assign rent = ents[g+1];
        assign rval = vals[g+1];
      end
      assign shift[g] = rm_now && (CW'(g) >= pos_r);
      assign load[g]  = app_now && (CW'(g) == count_r);
      ppq_cell u_cell (
        .clk(clk), .rst_n(rst_n), .shift(shift[g]), .load(load[g]),
        .load_entry(new_ent), .clear(1'b0), .right_entry(rent), .right_valid(rval),
        .entry(ents[g]), .valid(vals[g])
      );
    end
  endgenerate

  assign in_tready  = (state_r == S_IDLE) && !ovalid_r;
  assign out_tvalid = ovalid_r;
  assign out_tuser  = okind_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = {4'd0, oent_r.expire, oent_r.dst, oent_r.uid, oreason_r, ostatus_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      count_r   <= '0;
      pos_r     <= '0;
      ovalid_r  <= 1'b0;
      max_len_r <= 6'd32;
      timeout_r <= 32'd30000;
    end else begin
      if (cfg_we) begin
        if (cfg_index == ppq_pkg::CFG_MAX_LEN) max_len_r <= cfg_wdata[5:0];
        else timeout_r <= cfg_wdata;
      end
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (rm_now) count_r <= count_r - CW'(1);
      if (app_now) count_r <= count_r + CW'(1);
      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid && in_tready) begin
            mode_r   <= in_tdata[1:0];
            now_r    <= in_tdata[33:2];
            uid_r    <= in_tdata[65:34];
            dst_r    <= in_tdata[97:66];
            notify_r <= in_tdata[98];
            pos_r    <= '0;
            state_r  <= (in_tdata[1:0] == ppq_pkg::MODE_DROP) ? S_DROP : S_PURGE;
          end
        end
        S_PURGE: begin
          if (!ovalid_r || out_tready) begin
            if (pos_r >= count_r) begin
              pos_r   <= '0;
              state_r <= S_LOOK;
            end else if (rm_now) begin
              if (cur.notify) begin
                ovalid_r  <= 1'b1; okind_r <= 1'b0; ostatus_r <= ppq_pkg::ST_ENQUEUED;
                oreason_r <= 1'b0; olast_r <= 1'b0; oent_r <= cur;
              end
            end else if (!(cur.expire < now_r)) begin
              pos_r <= pos_r + CW'(1);
            end
          end
        end
        S_LOOK: begin
          if (!ovalid_r || out_tready) begin
            if (pos_r >= count_r) begin
              if (mode_r == ppq_pkg::MODE_ENQ) begin
                state_r <= (count_r >= limit && count_r != '0) ? S_EVICT : S_OUT;
                pos_r   <= '0;
              end else begin
                ovalid_r <= 1'b1; okind_r <= 1'b1; ostatus_r <= ppq_pkg::ST_NOTFOUND;
                oreason_r <= 1'b0; olast_r <= 1'b1; oent_r <= '0;
                state_r <= S_IDLE;
              end
            end else if (mode_r == ppq_pkg::MODE_ENQ) begin
              if (cur.uid == uid_r && cur.dst == dst_r) begin
                ovalid_r <= 1'b1; okind_r <= 1'b1; ostatus_r <= ppq_pkg::ST_DUP;
                oreason_r <= 1'b0; olast_r <= 1'b1; oent_r <= '0;
                state_r <= S_IDLE;
              end else begin
                pos_r <= pos_r + CW'(1);
              end
            end else if (cur.dst == dst_r) begin
              ovalid_r <= 1'b1; okind_r <= 1'b1; ostatus_r <= ppq_pkg::ST_FOUND;
              oreason_r <= 1'b0; olast_r <= 1'b1; oent_r <= cur;
              state_r <= S_IDLE;
            end else begin
              pos_r <= pos_r + CW'(1);
            end
          end
        end
        S_EVICT: begin
          if (!ovalid_r || out_tready) begin
            if (cur.notify) begin
              ovalid_r <= 1'b1; okind_r <= 1'b0; ostatus_r <= ppq_pkg::ST_ENQUEUED;
              oreason_r <= 1'b1; olast_r <= 1'b0; oent_r <= cur;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (!ovalid_r || out_tready) begin
            ovalid_r <= 1'b1; okind_r <= 1'b1; ostatus_r <= ppq_pkg::ST_ENQUEUED;
            oreason_r <= 1'b0; olast_r <= 1'b1; oent_r <= new_ent;
            state_r <= S_IDLE;
          end
        end
        S_DROP: begin
          if (!ovalid_r || out_tready) begin
            if (pos_r >= count_r) begin
              ovalid_r <= 1'b1; okind_r <= 1'b1; ostatus_r <= ppq_pkg::ST_DROPDONE;
              oreason_r <= 1'b0; olast_r <= 1'b1; oent_r <= '0;
              state_r <= S_IDLE;
            end else if (!rm_now) begin
              pos_r <= pos_r + CW'(1);
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: hw/rtl/ppq_cell.sv
// ----------------------------------------------------------------------------
// ppq_cell
// One slot. Loads a new entry, or takes its right neighbour's on a shift.
// ----------------------------------------------------------------------------
module ppq_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  logic             load,
  input  ppq_pkg::entry_t  load_entry,
  input  logic             clear,
  input  ppq_pkg::entry_t  right_entry,
  input  logic             right_valid,
  output ppq_pkg::entry_t  entry,
  output logic             valid
);
  ppq_pkg::entry_t entry_r;
  logic            valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (shift) begin
      valid_r <= right_valid;
    end else if (clear) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      entry_r <= load_entry;
    end else if (shift) begin
      entry_r <= right_entry;
    end
  end

  assign entry = entry_r;
  assign valid = valid_r;
endmodule

// File: hw/rtl/ppq_checker.sv
// ----------------------------------------------------------------------------
// ppq_checker
// Port-level checks of the pending packet queue, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module ppq_checker (
  input logic         clk,
  input logic         rst_n,
  input logic         in_tvalid,
  input logic         in_tready,
  input logic         out_tvalid,
  input logic         out_tready,
  input logic [103:0] out_tdata,
  input logic         out_tuser,
  input logic         out_tlast
);
  `ASSERT_IMPL(a_last_is_final, clk, rst_n, out_tvalid, out_tlast == out_tuser)
  `ASSERT_IMPL(a_note_status, clk, rst_n, out_tvalid && !out_tuser, out_tdata[2:0] == 3'd0)
  `ASSERT_IMPL(a_no_take_busy, clk, rst_n, out_tvalid, !in_tready)
  `ASSERT_NEXT(a_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata))
endmodule

bind pending_packet_queue_with_expiry ppq_checker u_ppq_checker (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser), .out_tlast(out_tlast)
);

// File: tb/sv/pending_packet_queue_with_expiry_test.sv
// ----------------------------------------------------------------------------
// pending_packet_queue_with_expiry_test
// Self-checking bench for the pending packet queue. Request words are driven
// with random gaps and the result side stalls at random. A tracker class keeps
// its own copy of the queue, predicts every result word of each accepted
// request and compares the words that come out, field by field, in order.
// ----------------------------------------------------------------------------
module pending_packet_queue_with_expiry_test;
  localparam int DEPTH = 32;
  localparam int LIMIT_CYCLES = 400000;
  localparam int SETTLE_CYCLES = 120;

  typedef struct packed {
    logic        kind;
    logic [2:0]  status;
    logic        reason;
    logic [31:0] uid;
    logic [31:0] dst;
    logic [31:0] expire;
    logic        last;
  } result_word_t;

  class queue_tracker;
    logic [31:0]  q_uid[DEPTH];
    logic [31:0]  q_dst[DEPTH];
    logic [31:0]  q_exp[DEPTH];
    logic         q_ntf[DEPTH];
    int           count;
    logic [5:0]   max_len;
    logic [31:0]  timeout;
    result_word_t expected_words[$];
    int           errors;

    function new();
      count = 0;
      max_len = 6'd32;
      timeout = 32'd30000;
      errors = 0;
    endfunction

    function void write_reg(logic idx, logic [31:0] value);
      if (idx == ppq_pkg::CFG_MAX_LEN) max_len = value[5:0];
      else timeout = value;
    endfunction

    function void remove_at(int i);
      for (int j = i; j + 1 < count; j++) begin
        q_uid[j] = q_uid[j + 1];
        q_dst[j] = q_dst[j + 1];
        q_exp[j] = q_exp[j + 1];
        q_ntf[j] = q_ntf[j + 1];
      end
      count--;
    endfunction

    function void push(logic kind, logic [2:0] st, logic rsn, logic [31:0] u,
                       logic [31:0] d, logic [31:0] e, logic lst);
      result_word_t w;
      w.kind = kind; w.status = st; w.reason = rsn;
      w.uid = u; w.dst = d; w.expire = e; w.last = lst;
      expected_words.insert(expected_words.size(), w);
    endfunction

    function void note_request(logic [1:0] mode, logic [31:0] now, logic [31:0] uid,
                               logic [31:0] dst, logic ntf);
      int i;
      int lim;
      logic [32:0] sum;
      logic [31:0] exp_t;
      if (mode == ppq_pkg::MODE_DROP) begin
        i = 0;
        while (i < count) begin
          if (q_dst[i] == dst) remove_at(i);
          else i++;
        end
        push(1'b1, ppq_pkg::ST_DROPDONE, 1'b0, '0, '0, '0, 1'b1);
        return;
      end
      i = 0;
      while (i < count) begin
        if (q_exp[i] < now) begin
          if (q_ntf[i]) begin
            push(1'b0, ppq_pkg::ST_ENQUEUED, 1'b0, q_uid[i], q_dst[i], q_exp[i], 1'b0);
          end
          remove_at(i);
        end else begin
          i++;
        end
      end
      if (mode == ppq_pkg::MODE_ENQ) begin
        for (int k = 0; k < count; k++) begin
          if (q_uid[k] == uid && q_dst[k] == dst) begin
            push(1'b1, ppq_pkg::ST_DUP, 1'b0, '0, '0, '0, 1'b1);
            return;
          end
        end
        sum = {1'b0, now} + {1'b0, timeout};
        exp_t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        lim = (max_len == 0) ? 1 : ((max_len > DEPTH) ? DEPTH : int'(max_len));
        if (count >= lim && count > 0) begin
          if (q_ntf[0]) begin
            push(1'b0, ppq_pkg::ST_ENQUEUED, 1'b1, q_uid[0], q_dst[0], q_exp[0], 1'b0);
          end
          remove_at(0);
        end
        if (count < DEPTH) begin
          q_uid[count] = uid; q_dst[count] = dst;
          q_exp[count] = exp_t; q_ntf[count] = ntf;
          count++;
        end
        push(1'b1, ppq_pkg::ST_ENQUEUED, 1'b0, uid, dst, exp_t, 1'b1);
        return;
      end
      for (int k = 0; k < count; k++) begin
        if (q_dst[k] == dst) begin
          push(1'b1, ppq_pkg::ST_FOUND, 1'b0, q_uid[k], q_dst[k], q_exp[k], 1'b1);
          if (mode == ppq_pkg::MODE_DEQ) remove_at(k);
          return;
        end
      end
      push(1'b1, ppq_pkg::ST_NOTFOUND, 1'b0, '0, '0, '0, 1'b1);
    endfunction

    function void check_word(result_word_t got);
      result_word_t w;
      if (expected_words.size() == 0) begin
        $display("%0t: unexpected result word kind=%0d status=%0d uid=%h", $time,
                 got.kind, got.status, got.uid);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      if (got !== w) begin
        $display("%0t: mismatch expected kind=%0d st=%0d rsn=%0d uid=%h dst=%h exp=%h last=%0d",
                 $time, w.kind, w.status, w.reason, w.uid, w.dst, w.expire, w.last);
        $display("%0t:          actual   kind=%0d st=%0d rsn=%0d uid=%h dst=%h exp=%h last=%0d",
                 $time, got.kind, got.status, got.reason, got.uid, got.dst, got.expire,
                 got.last);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [103:0] in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [103:0] out_tdata;
  logic         out_tuser;
  logic         out_tlast;
  logic         cfg_we = 1'b0;
  logic [0:0]   cfg_index = '0;
  logic [31:0]  cfg_wdata = '0;

  queue_tracker tracker = new();
  int           accepted_words = 0;
  int           cycles = 0;
  bit           no_idle = 1'b0;
  bit           hold_off = 1'b0;
  logic [31:0]  clock_now = '0;

  always #5 clk = ~clk;

  pending_packet_queue_with_expiry #(.QUEUE_DEPTH(DEPTH)) dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always @(posedge clk) begin
    result_word_t got;
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("FAIL pending_packet_queue_with_expiry");
      $finish;
    end
    if (rst_n && in_tvalid && in_tready) begin
      tracker.note_request(in_tdata[1:0], in_tdata[33:2], in_tdata[65:34],
                           in_tdata[97:66], in_tdata[98]);
      accepted_words++;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got.kind = out_tuser;
      got.status = out_tdata[2:0];
      got.reason = out_tdata[3];
      got.uid = out_tdata[35:4];
      got.dst = out_tdata[67:36];
      got.expire = out_tdata[99:68];
      got.last = out_tlast;
      tracker.check_word(got);
    end
  end

  always @(negedge clk) begin
    if (hold_off) out_tready = 1'b0;
    else if (no_idle) out_tready = 1'b1;
    else out_tready = ($urandom_range(99) >= 17);
  end

  task automatic send_request(logic [1:0] mode, logic [31:0] now, logic [31:0] uid,
                              logic [31:0] dst, logic ntf);
    int seen;
    seen = accepted_words;
    in_tdata = {5'b0, ntf, dst, uid, now, mode};
    in_tvalid = 1'b1;
    do @(negedge clk); while (accepted_words == seen);
    if (!no_idle && $urandom_range(99) < 17) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(6, 1)) @(negedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (tracker.expected_words.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_wdata = value;
    @(negedge clk);
    tracker.write_reg(idx, value);
    cfg_we = 1'b0;
  endtask

  task automatic random_requests(int n, int step_max, logic [31:0] dst_base);
    logic [1:0]  mode;
    logic [31:0] uid;
    logic [31:0] dst;
    int          r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      mode = (r < 45) ? ppq_pkg::MODE_ENQ : (r < 65) ? ppq_pkg::MODE_DEQ :
             (r < 85) ? ppq_pkg::MODE_FIND : ppq_pkg::MODE_DROP;
      if ($urandom_range(9) == 0) clock_now = $urandom();
      else clock_now = clock_now + $urandom_range(step_max);
      uid = ($urandom_range(4) == 0) ? $urandom() : 32'($urandom_range(7));
      dst = ($urandom_range(5) == 0) ? $urandom() : dst_base + $urandom_range(3);
      send_request(mode, clock_now, uid, dst, 1'($urandom()));
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd2);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'd10);

    send_request(ppq_pkg::MODE_ENQ, 32'd0, 32'd1, 32'd1, 1'b1);
    send_request(ppq_pkg::MODE_ENQ, 32'd1, 32'd1, 32'd1, 1'b0);
    send_request(ppq_pkg::MODE_ENQ, 32'd2, 32'd2, 32'd2, 1'b1);
    send_request(ppq_pkg::MODE_ENQ, 32'd3, 32'd3, 32'd3, 1'b1);
    send_request(ppq_pkg::MODE_FIND, 32'd4, 32'd0, 32'd2, 1'b0);
    send_request(ppq_pkg::MODE_DEQ, 32'd4, 32'd0, 32'd2, 1'b0);
    send_request(ppq_pkg::MODE_DEQ, 32'd4, 32'd0, 32'd2, 1'b0);
    send_request(ppq_pkg::MODE_FIND, 32'd4, 32'd0, 32'd9, 1'b0);
    send_request(ppq_pkg::MODE_ENQ, 32'd5, 32'd4, 32'd3, 1'b0);
    send_request(ppq_pkg::MODE_DROP, 32'd5, 32'd0, 32'd3, 1'b0);
    send_request(ppq_pkg::MODE_ENQ, 32'd10, 32'd5, 32'd5, 1'b1);
    send_request(ppq_pkg::MODE_ENQ, 32'd10, 32'd6, 32'd6, 1'b0);
    send_request(ppq_pkg::MODE_FIND, 32'd21, 32'd0, 32'd5, 1'b0);
    send_request(ppq_pkg::MODE_ENQ, 32'd30, 32'd7, 32'd7, 1'b1);
    send_request(ppq_pkg::MODE_FIND, 32'd40, 32'd0, 32'd7, 1'b0);
    send_request(ppq_pkg::MODE_ENQ, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_request(ppq_pkg::MODE_DEQ, 32'hFFFF_FFF0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    send_request(ppq_pkg::MODE_DROP, 32'd0, 32'd0, 32'hFFFF_FFFF, 1'b0);
    drain();

    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd0);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'hFFFF_FFFF);
    send_request(ppq_pkg::MODE_ENQ, 32'd100, 32'd8, 32'd8, 1'b1);
    send_request(ppq_pkg::MODE_ENQ, 32'd100, 32'd9, 32'd9, 1'b1);
    send_request(ppq_pkg::MODE_DROP, 32'd100, 32'd0, 32'd9, 1'b0);
    drain();

    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd4);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'd60);
    clock_now = 32'd1000;
    random_requests(30, 25, 32'h0A00_0000);
    drain();

    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd63);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'd2000);
    no_idle = 1'b1;
    random_requests(15, 40, 32'hC0A8_0100);
    no_idle = 1'b0;
    hold_off = 1'b1;
    fork
      random_requests(10, 40, 32'hC0A8_0100);
      begin
        repeat (600) @(negedge clk);
        hold_off = 1'b0;
      end
    join
    drain();

    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd1);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'd0);
    random_requests(15, 3, 32'hFFFF_FFFC);
    drain();

    write_reg(ppq_pkg::CFG_MAX_LEN, 32'd32);
    write_reg(ppq_pkg::CFG_TIMEOUT, 32'hFFFF_FF00);
    random_requests(20, 500, 32'h0000_0000);
    drain();

    if (tracker.errors == 0) $display("PASS pending_packet_queue_with_expiry");
    else $display("FAIL pending_packet_queue_with_expiry");
    $finish;
  end
endmodule
